>>> src/wce_pkg.sv
// Package for the waveform column envelope unit: field widths, the block
// job word passed from front to back, and the back-end state encoding.
// No dependencies.
`default_nettype none

package wce_pkg;

  // field and state widths
  localparam int SMPW  = 16;   // sample word, Q1.15
  localparam int MAGW  = 17;   // magnitude of a negative sample, 1..32768
  localparam int BSW   = 12;   // block_size register
  localparam int SCW   = 13;   // height_scale register
  localparam int CCW   = 11;   // column_count register
  localparam int PSW   = 27;   // positive sum
  localparam int NSW   = 28;   // negative sum
  localparam int CNTW  = 12;   // per-side sample count
  localparam int HTW   = 16;   // height word
  localparam int PRODW = NSW + SCW;       // sum times scale
  localparam int FRAC_BITS = 15;          // Q1.15 fraction bits
  localparam int DIVW  = PRODW - FRAC_BITS; // dividend after fraction drop

  // job queue
  localparam int QD   = 2;
  localparam int QPW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;

  // register reset values
  localparam logic [BSW-1:0] BLOCK_SIZE_RST   = 12'd96;
  localparam logic [SCW-1:0] HEIGHT_SCALE_RST = 13'd64;
  localparam logic [CCW-1:0] COLUMN_COUNT_RST = 11'd512;

  // one finished block, as handed to the back end
  typedef struct packed {
    logic [PSW-1:0]  psum;
    logic [CNTW-1:0] pcnt;
    logic [NSW-1:0]  nsum;
    logic [CNTW-1:0] ncnt;
    logic            backward;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NORM,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

>>> src/wce_front.sv
// Front end: takes one sample word per cycle (a block-closing word waits
// while the queue is full), accumulates both sides of the current block
// and pushes a job when the block completes. Depends on wce_pkg.
`default_nettype none

module wce_front import wce_pkg::*; #(
  parameter int MAX_BLOCK = 4095
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire logic [SMPW-1:0] sample_value,
  input  wire logic            in_range,
  input  wire logic            backward,
  input  wire logic [BSW-1:0]  block_size,
  input  wire logic            q_full,
  output      logic            push,
  output      job_t            job
);

  logic [PSW-1:0]  psum_r, psum_nxt;
  logic [NSW-1:0]  nsum_r, nsum_nxt;
  logic [CNTW-1:0] pcnt_r, pcnt_nxt;
  logic [CNTW-1:0] ncnt_r, ncnt_nxt;
  logic [BSW-1:0]  sib_r;
  logic [BSW-1:0]  bs_eff;
  logic            last_item;
  logic            accept;
  logic            is_neg;
  logic [MAGW-1:0] mag;

  // clamp block size to 1..MAX_BLOCK
  always_comb begin
    if (block_size == '0) begin
      bs_eff = BSW'(1);
    end else if (32'(block_size) > 32'(MAX_BLOCK)) begin
      bs_eff = BSW'(MAX_BLOCK);
    end else begin
      bs_eff = block_size;
    end
  end

  assign last_item = ((BSW+1)'(sib_r) + (BSW+1)'(1)) >= (BSW+1)'(bs_eff);
  // only a block-closing word needs room in the queue
  assign in_ready  = !last_item || !q_full;
  assign accept    = in_valid && in_ready;

  // sums including the current word
  assign is_neg = sample_value[SMPW-1];
  assign mag    = MAGW'(17'h10000) - MAGW'(sample_value);

  always_comb begin
    psum_nxt = psum_r + ((in_range && !is_neg) ? PSW'(sample_value[SMPW-2:0]) : '0);
    pcnt_nxt = pcnt_r + ((in_range && !is_neg) ? CNTW'(1) : '0);
    nsum_nxt = nsum_r + ((in_range && is_neg) ? NSW'(mag) : '0);
    ncnt_nxt = ncnt_r + ((in_range && is_neg) ? CNTW'(1) : '0);
  end

  assign push         = accept && last_item;
  assign job.psum     = psum_nxt;
  assign job.pcnt     = pcnt_nxt;
  assign job.nsum     = nsum_nxt;
  assign job.ncnt     = ncnt_nxt;
  assign job.backward = backward;

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
      nsum_r <= '0;
      pcnt_r <= '0;
      ncnt_r <= '0;
      sib_r  <= '0;
    end else if (accept) begin
      if (last_item) begin
        psum_r <= '0;
        nsum_r <= '0;
        pcnt_r <= '0;
        ncnt_r <= '0;
        sib_r  <= '0;
      end else begin
        psum_r <= psum_nxt;
        nsum_r <= nsum_nxt;
        pcnt_r <= pcnt_nxt;
        ncnt_r <= ncnt_nxt;
        sib_r  <= sib_r + BSW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/wce_queue.sv
// Short job queue between front and back end.
// Depends on wce_pkg.
`default_nettype none

module wce_queue import wce_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output      job_t pop_data,
  output      logic empty,
  output      logic full
);

  job_t           mem_r [QD];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == QCW'(QD));
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QD - 1)) ? '0 : wr_ptr_r + QPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QD - 1)) ? '0 : rd_ptr_r + QPW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/wce_back.sv
// Back end: per job, scales and divides each side with a shared multiplier
// and a bit-serial divider, steps the ring head and fills the output word;
// on norm_start in B_IDLE or B_NORM it reduces the head modulo the ring length. Depends on wce_pkg.
`default_nettype none

module wce_back import wce_pkg::*; #(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  output      logic                             q_pop,
  input  wire job_t                             job_in,
  input  wire logic [SCW-1:0]                   height_scale,
  input  wire logic [CCW-1:0]                   column_count,
  input  wire logic                             norm_start,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [$clog2(MAX_COLUMNS)-1:0]   out_index,
  output      logic [HTW-1:0]                   out_pos,
  output      logic [HTW-1:0]                   out_neg
);

  localparam int HW  = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int LW  = HW + CW;
  localparam int KW  = $clog2(HW + 1);
  localparam int DCW = $clog2(DIVW);

  back_state_t     state_r, state_nxt;
  job_t            job_r, job_nxt;
  logic            side_r, side_nxt;
  logic [DIVW-1:0] n_r, n_nxt;
  logic [CNTW-1:0] rem_r, rem_nxt;
  logic [DCW-1:0]  dcnt_r, dcnt_nxt;
  logic [HTW-1:0]  pos_h_r, pos_h_nxt;
  logic [HTW-1:0]  neg_h_r, neg_h_nxt;
  logic [HW-1:0]   head_r, head_nxt;
  logic [HW-1:0]   head_mod_r, head_mod_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [HW-1:0]   out_idx_r, out_idx_nxt;
  logic [HTW-1:0]  out_pos_r, out_pos_nxt;
  logic [HTW-1:0]  out_neg_r, out_neg_nxt;

  logic [CW-1:0]    cc_eff;
  logic [CNTW-1:0]  cnt_sel;
  logic [NSW-1:0]   sum_sel;
  logic [PRODW-1:0] prod;
  logic [CNTW:0]    rem_sh;
  logic             ge;
  logic [CNTW:0]    rem_sub;
  logic [DIVW-1:0]  quot;
  logic [HTW-1:0]   height;
  logic [LW-1:0]    sh_cc;
  logic             ge_n;
  logic [CW-1:0]    head_plus;
  logic [HW-1:0]    head_step;

  // ring length clamped to 1..MAX_COLUMNS
  always_comb begin
    if (column_count == '0) begin
      cc_eff = CW'(1);
    end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
      cc_eff = CW'(MAX_COLUMNS);
    end else begin
      cc_eff = CW'(column_count);
    end
  end

  // side select and scale multiply
  assign cnt_sel = side_r ? job_r.ncnt : job_r.pcnt;
  assign sum_sel = side_r ? job_r.nsum : NSW'(job_r.psum);
  assign prod    = sum_sel * height_scale;

  // one restoring division step per cycle
  assign rem_sh  = {rem_r, n_r[DIVW-1]};
  assign ge      = rem_sh >= {1'b0, cnt_sel};
  assign rem_sub = rem_sh - {1'b0, cnt_sel};
  assign quot    = {n_r[DIVW-2:0], ge};

  // zero count gives zero, else saturate to 16 bits
  always_comb begin
    if (cnt_sel == '0) begin
      height = '0;
    end else if (|quot[DIVW-1:HTW]) begin
      height = '1;
    end else begin
      height = quot[HTW-1:0];
    end
  end

  // head modulo ring length, one quotient bit per cycle; the raw head is
  // kept so that a later, larger ring sees the head as it was stepped
  assign sh_cc = LW'(cc_eff) << k_r;
  assign ge_n  = LW'(head_mod_r) >= sh_cc;

  // ring step with wrap
  assign head_plus = CW'(head_mod_r) + CW'(1);
  always_comb begin
    if (job_r.backward) begin
      head_step = (head_mod_r == '0) ? HW'(cc_eff - CW'(1)) : head_mod_r - HW'(1);
    end else begin
      head_step = (head_plus >= cc_eff) ? '0 : head_plus[HW-1:0];
    end
  end

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    side_nxt      = side_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    pos_h_nxt     = pos_h_r;
    neg_h_nxt     = neg_h_r;
    head_nxt      = head_r;
    head_mod_nxt  = head_mod_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_pos_nxt   = out_pos_r;
    out_neg_nxt   = out_neg_r;
    q_pop         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      B_IDLE: begin
        if (norm_start) begin
          head_mod_nxt = head_r;
          k_nxt        = KW'(HW - 1);
          state_nxt    = B_NORM;
        end else if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = job_in;
          side_nxt  = 1'b0;
          state_nxt = B_MUL;
        end
      end
      B_NORM: begin
        if (norm_start) begin
          head_mod_nxt = head_r;
          k_nxt        = KW'(HW - 1);
        end else begin
          if (ge_n) begin
            head_mod_nxt = head_mod_r - sh_cc[HW-1:0];
          end
          if (k_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            k_nxt = k_r - KW'(1);
          end
        end
      end
      B_MUL: begin
        n_nxt     = prod[PRODW-1:FRAC_BITS];
        rem_nxt   = '0;
        dcnt_nxt  = DCW'(DIVW - 1);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        rem_nxt = ge ? rem_sub[CNTW-1:0] : rem_sh[CNTW-1:0];
        n_nxt   = quot;
        if (dcnt_r == '0) begin
          if (side_r) begin
            neg_h_nxt = height;
            state_nxt = B_DONE;
          end else begin
            pos_h_nxt = height;
            side_nxt  = 1'b1;
            state_nxt = B_MUL;
          end
        end else begin
          dcnt_nxt = dcnt_r - DCW'(1);
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = head_mod_r;
          out_pos_nxt   = pos_h_r;
          out_neg_nxt   = neg_h_r;
          head_nxt      = head_step;
          head_mod_nxt  = head_step;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      head_mod_r  <= '0;
      out_valid_r <= 1'b0;
      side_r      <= 1'b0;
      k_r         <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      head_mod_r  <= head_mod_nxt;
      out_valid_r <= out_valid_nxt;
      side_r      <= side_nxt;
      k_r         <= k_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    n_r       <= n_nxt;
    rem_r     <= rem_nxt;
    pos_h_r   <= pos_h_nxt;
    neg_h_r   <= neg_h_nxt;
    out_idx_r <= out_idx_nxt;
    out_pos_r <= out_pos_nxt;
    out_neg_r <= out_neg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_index = out_idx_r;
  assign out_pos   = out_pos_r;
  assign out_neg   = out_neg_r;

endmodule

`default_nettype wire

>>> src/waveform_column_envelope_unit.sv
// Waveform column envelope unit. Samples are taken at one word per cycle,
// but a block-closing word waits while the job queue is full. The back end
// takes one job at a time and forms each column word with two 26-step serial
// divisions, one multiply each; blocks closing faster than it finishes jobs
// stall input once the two-entry job queue fills. Synchronous active-low reset
// clears accumulators, queue, ring head (to 0) and loads default register values.
`default_nettype none

module waveform_column_envelope_unit import wce_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_BLOCK   = 4095
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input stream
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  input  wire logic [SMPW-1:0]     in_tdata,   // [15:0] sample_value
  input  wire logic [1:0]          in_tuser,   // [0] in_range, [1] backward
  // result stream
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  // [HW-1:0] column_index, then positive_height, negative_height,
  // packed_column (32), zero padded to whole bytes
  output      logic [(($clog2(MAX_COLUMNS) + 2*HTW + 2*HTW + 7) / 8) * 8 - 1:0] out_tdata,
  // configuration
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CFG_AW-1:0]   cfg_paddr,
  input  wire logic [CFG_DW-1:0]   cfg_pwdata,
  output      logic [CFG_DW-1:0]   cfg_prdata,
  output      logic                cfg_pready
);

  localparam int HW     = $clog2(MAX_COLUMNS);
  localparam int OUT_DW = ((HW + 4*HTW + 7) / 8) * 8;

  logic [BSW-1:0] block_size_r;
  logic [SCW-1:0] height_scale_r;
  logic [CCW-1:0] column_count_r;
  logic           cfg_write;
  logic [1:0]     cfg_index;
  logic           norm_start;

  logic           q_push;
  logic           q_pop;
  job_t           q_in;
  job_t           q_out;
  logic           q_empty;
  logic           q_full;

  logic [HW-1:0]  out_idx;
  logic [HTW-1:0] out_pos;
  logic [HTW-1:0] out_neg;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_index  = cfg_paddr[3:2];
  assign norm_start = cfg_write && (cfg_index == REG_COLUMN_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= BLOCK_SIZE_RST;
      height_scale_r <= HEIGHT_SCALE_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size_r   <= cfg_pwdata[BSW-1:0];
        REG_HEIGHT_SCALE: height_scale_r <= cfg_pwdata[SCW-1:0];
        REG_COLUMN_COUNT: column_count_r <= cfg_pwdata[CCW-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_index)
      REG_BLOCK_SIZE:   cfg_prdata = CFG_DW'(block_size_r);
      REG_HEIGHT_SCALE: cfg_prdata = CFG_DW'(height_scale_r);
      REG_COLUMN_COUNT: cfg_prdata = CFG_DW'(column_count_r);
      default:          cfg_prdata = '0;
    endcase
  end

  wce_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .sample_value (in_tdata),
    .in_range     (in_tuser[0]),
    .backward     (in_tuser[1]),
    .block_size   (block_size_r),
    .q_full       (q_full),
    .push         (q_push),
    .job          (q_in)
  );

  wce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  wce_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .job_in       (q_out),
    .height_scale (height_scale_r),
    .column_count (column_count_r),
    .norm_start   (norm_start),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_index    (out_idx),
    .out_pos      (out_pos),
    .out_neg      (out_neg)
  );

  // result word: index, positive, negative, then packed column
  assign out_tdata = OUT_DW'({out_neg, out_pos, out_neg, out_pos, out_idx});

endmodule

`default_nettype wire
